/* src/chbd_pkg.sv */
// Package with types, constants and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package chbd_pkg;

   localparam int BYTE_W   = 8;
   localparam int SIZE_W   = 32;
   localparam int DIGIT_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic [DIGIT_W-1:0] MAX_HEX_DIGITS = 4'd8;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

   localparam logic [SIZE_W-1:0] SIZE_SAT_LIMIT = 32'h0FFF_FFFF;

   typedef enum logic [2:0] {
      PH_SIZE     = 3'd0,
      PH_DATA     = 3'd1,
      PH_AFTER    = 3'd2,
      PH_AFTER_CR = 3'd3,
      PH_DONE     = 3'd4,
      PH_ERROR    = 3'd5
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   // Outcome of one byte of a size line.
   typedef struct packed {
      phase_type            phase;
      logic [SIZE_W-1:0]    size;
      logic [DIGIT_W-1:0]   digits;
   } size_line_type;

   // One decoded result beat.
   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte;
      logic                 byte_valid;
      status_type           decode_status;
   } result_type;

   typedef struct packed {
      logic                 is_hex;
      logic [3:0]           value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_type h;
      h.is_hex = 1'b1;
      h.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         // 'a'..'f' and 'A'..'F' share low bits 1..6
         h.value = c[3:0] + 4'd9;
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

/* src/chbd_if.sv */
// Handshake channel interfaces for raw body bytes and decoded results.
`timescale 1ns / 1ps

interface chbd_req_if;
   import chbd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chbd_rsp_if;
   import chbd_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                byte_valid;
   logic [STATUS_W-1:0] decode_status;

   modport source (output valid, output out_byte, output byte_valid,
                   output decode_status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input decode_status, output ready);
endinterface

/* src/chbd_size_line.sv */
// Size line byte handling: hex accumulation, line end and error detection.
`timescale 1ns / 1ps

module chbd_size_line #(
   parameter logic [chbd_pkg::DIGIT_W-1:0] MAX_DIGITS = chbd_pkg::MAX_HEX_DIGITS
) (
   input  logic [chbd_pkg::BYTE_W-1:0]  data_byte,
   input  logic [chbd_pkg::SIZE_W-1:0]  size_cur,
   input  logic [chbd_pkg::DIGIT_W-1:0] digits_cur,
   output chbd_pkg::size_line_type      line_next
);
   import chbd_pkg::*;

   hex_type hex;

   assign hex = hex_decode(data_byte);

   always_comb begin
      line_next.phase  = PH_SIZE;
      line_next.size   = size_cur;
      line_next.digits = digits_cur;
      if (data_byte == CHAR_CR) begin
         // skip carriage returns inside the size line
         line_next.phase = PH_SIZE;
      end else if (data_byte == CHAR_LF) begin
         line_next.digits = '0;
         if (digits_cur == '0) begin
            line_next.phase = PH_ERROR;
         end else if (size_cur == '0) begin
            line_next.phase = PH_DONE;
         end else begin
            line_next.phase = PH_DATA;
         end
      end else if (!hex.is_hex || digits_cur >= MAX_DIGITS) begin
         line_next.phase = PH_ERROR;
      end else begin
         line_next.digits = digits_cur + 4'd1;
         if (size_cur > SIZE_SAT_LIMIT) begin
            line_next.size = '1;
         end else begin
            line_next.size = {size_cur[SIZE_W-5:0], hex.value};
         end
      end
   end

endmodule

/* src/chbd_core.sv */
// Decoder state machine: phase, chunk size and digit count, one byte per step.
`timescale 1ns / 1ps

module chbd_core #(
   parameter logic [chbd_pkg::DIGIT_W-1:0] MAX_DIGITS = chbd_pkg::MAX_HEX_DIGITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [chbd_pkg::BYTE_W-1:0] data_byte,
   input  logic                        last_byte,
   output chbd_pkg::result_type        result
);
   import chbd_pkg::*;

   phase_type            phase_ff, phase_in, phase_walk;
   logic [SIZE_W-1:0]    size_ff, size_in, size_walk;
   logic [DIGIT_W-1:0]   digit_ff, digit_in, digit_walk;
   logic                 use_line;
   size_line_type        line_next;

   chbd_size_line #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_size_line (
      .data_byte  (data_byte),
      .size_cur   (size_ff),
      .digits_cur (digit_ff),
      .line_next  (line_next)
   );

   // next state
   always_comb begin
      use_line   = 1'b0;
      phase_walk = phase_ff;
      size_walk  = size_ff;
      digit_walk = digit_ff;
      case (phase_ff)
         PH_SIZE: begin
            use_line = 1'b1;
         end
         PH_DATA: begin
            size_walk = size_ff - 32'd1;
            if (size_walk == '0) begin
               phase_walk = PH_AFTER;
            end
         end
         PH_AFTER: begin
            if (data_byte == CHAR_CR) begin
               phase_walk = PH_AFTER_CR;
            end else if (data_byte == CHAR_LF) begin
               phase_walk = PH_SIZE;
            end else begin
               use_line = 1'b1;
            end
         end
         PH_AFTER_CR: begin
            phase_walk = PH_SIZE;
            if (data_byte != CHAR_LF) begin
               use_line = 1'b1;
            end
         end
         PH_DONE: begin
            phase_walk = PH_DONE;
         end
         default: begin
            phase_walk = PH_ERROR;
         end
      endcase
      if (use_line) begin
         phase_walk = line_next.phase;
         size_walk  = line_next.size;
         digit_walk = line_next.digits;
      end

      phase_in = phase_walk;
      if (last_byte) begin
         // a size line of value zero pending its LF still counts as complete
         if (phase_walk == PH_SIZE && digit_walk != '0 && size_walk == '0) begin
            phase_in = PH_DONE;
         end else if (phase_walk != PH_DONE) begin
            phase_in = PH_ERROR;
         end
      end
      size_in  = size_walk;
      digit_in = digit_walk;
   end

   // outputs
   always_comb begin
      result.byte_valid = (phase_ff == PH_DATA);
      result.out_byte   = (phase_ff == PH_DATA) ? data_byte : '0;
      case (phase_in)
         PH_DONE:  result.decode_status = ST_DONE;
         PH_ERROR: result.decode_status = ST_ERROR;
         default:  result.decode_status = ST_BUSY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         size_ff  <= '0;
         digit_ff <= '0;
      end else if (step) begin
         if (last_byte) begin
            // re-arm for the next body
            phase_ff <= PH_SIZE;
            size_ff  <= '0;
            digit_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            size_ff  <= size_in;
            digit_ff <= digit_in;
         end
      end
   end

endmodule

/* src/http_chunked_body_decoder.sv */
// Top level of the chunked body decoder: input register, decoder, result register.
// Path: a req beat is held in the input register, passes through the decoder into the
//   result register, and its rsp beat is offered from there.
// Throughput: one byte per cycle while rsp is not stalled, bounded by the decoder state loop.
// Backpressure: req is taken while the input register is empty or moves into a free
//   result register; with rsp stalled, two beats are held before req stalls.
// Reset: synchronous; empties both registers and returns the decoder to the size line.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
   parameter logic [chbd_pkg::DIGIT_W-1:0] MAX_DIGITS = chbd_pkg::MAX_HEX_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   chbd_req_if.sink    req_chan,
   chbd_rsp_if.source  rsp_chan
);
   import chbd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   result_type        result;
   logic              out_free;
   logic              advance;
   logic              req_take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   chbd_core #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold until the beat moves on
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_byte      = rsp_ff.out_byte;
   assign rsp_chan.byte_valid    = rsp_ff.byte_valid;
   assign rsp_chan.decode_status = rsp_ff.decode_status;

   a_byte_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.byte_valid |-> rsp_ff.out_byte == '0)
      else $error("out_byte nonzero without a payload byte");

   a_no_payload_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_valid |-> rsp_ff.decode_status != ST_DONE)
      else $error("payload byte reported with decode complete");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("decoded beat lost between registers");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_take)
      else $error("input register overwritten while held");

endmodule
